>>> hw/rtl/fss_pkg.sv
package fss_pkg;

    localparam int unsigned THROTTLE_W = 11;
    localparam int unsigned YAW_W = 12;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned MOTOR_W = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    localparam int unsigned LEVEL_W = 11;
    localparam int unsigned ANGLE_LIMIT_W = 15;
    localparam int unsigned FREEZE_W = 16;

    localparam logic [LEVEL_W-1:0] YAW_ARM_LEVEL_RESET = 11'd450;
    localparam logic [ANGLE_LIMIT_W-1:0] SAFE_ANGLE_RESET = 15'd720;
    localparam logic [THROTTLE_W-1:0] THROTTLE_MINIMUM_RESET = 11'd100;
    localparam logic [FREEZE_W-1:0] FREEZE_LIMIT_RESET = 16'd500;
    localparam logic ANGLE_STOP_ENABLE_RESET = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_YAW_ARM_LEVEL = 3'd0,
        CFG_SAFE_ANGLE = 3'd1,
        CFG_THROTTLE_MINIMUM = 3'd2,
        CFG_FREEZE_LIMIT = 3'd3,
        CFG_ANGLE_STOP_ENABLE = 3'd4
    } fss_cfg_idx_t;

    typedef enum logic [1:0] {
        EMERG_NONE = 2'd0,
        EMERG_GYRO_FROZEN = 2'd1,
        EMERG_ANGLE = 2'd2
    } fss_emerg_t;

    typedef struct packed {
        logic [THROTTLE_W-1:0] throttle;
        logic signed [SAMPLE_W-1:0] ctrl_roll;
        logic signed [SAMPLE_W-1:0] ctrl_pitch;
        logic signed [SAMPLE_W-1:0] ctrl_yaw;
        logic motors_on;
        logic armed;
        fss_emerg_t emergency;
        logic hold_integral;
    } fss_cmd_t;

endpackage

>>> hw/rtl/flight_safety_supervisor_mixer.sv
// Flight safety supervisor and X-quad motor mixer. Each push carries one control tick and
// yields exactly one result, in order. The front stage applies stick arming, the gyro freeze
// watchdog and the tilt stop, and updates the latched state in the cycle of the push; the back
// stage mixes, rounds and saturates the four motor commands into an output register. A command
// queue of QUEUE_DEPTH entries sits between them, so a new tick is taken every cycle while
// the queue has room; a result passes through the queue and then into the output register,
// which takes it while it is empty or being popped. An emergency stays latched until reset.
// Configuration registers are written through cfg_write, cfg_index and cfg_data; unused
// indexes are ignored.
module flight_safety_supervisor_mixer #(
    parameter int unsigned QUEUE_DEPTH = fss_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  logic [fss_pkg::THROTTLE_W-1:0] throttle,
    input  logic signed [fss_pkg::YAW_W-1:0] yaw_stick,
    input  logic signed [fss_pkg::SAMPLE_W-1:0] gyro_roll_rate,
    input  logic signed [fss_pkg::SAMPLE_W-1:0] roll_angle,
    input  logic signed [fss_pkg::SAMPLE_W-1:0] pitch_angle,
    input  logic signed [fss_pkg::SAMPLE_W-1:0] ctrl_roll,
    input  logic signed [fss_pkg::SAMPLE_W-1:0] ctrl_pitch,
    input  logic signed [fss_pkg::SAMPLE_W-1:0] ctrl_yaw,
    output logic empty,
    input  logic pop,
    output logic signed [fss_pkg::MOTOR_W-1:0] motor_front_right,
    output logic signed [fss_pkg::MOTOR_W-1:0] motor_back_left,
    output logic signed [fss_pkg::MOTOR_W-1:0] motor_front_left,
    output logic signed [fss_pkg::MOTOR_W-1:0] motor_back_right,
    output logic motors_on,
    output logic armed,
    output logic [1:0] emergency,
    output logic hold_integral,
    input  logic cfg_write,
    input  logic [fss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fss_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fss_pkg::*;

    logic accept;
    fss_cmd_t front_cmd;
    fss_cmd_t queue_cmd;
    logic queue_empty;
    logic queue_take;

    assign accept = push && !full;

    fss_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .throttle(throttle),
        .yaw_stick(yaw_stick),
        .gyro_roll_rate(gyro_roll_rate),
        .roll_angle(roll_angle),
        .pitch_angle(pitch_angle),
        .ctrl_roll(ctrl_roll),
        .ctrl_pitch(ctrl_pitch),
        .ctrl_yaw(ctrl_yaw),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cmd(front_cmd)
    );

    fss_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(accept),
        .wr_cmd(front_cmd),
        .full(full),
        .rd_en(queue_take),
        .empty(queue_empty),
        .rd_cmd(queue_cmd)
    );

    fss_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(!queue_empty),
        .cmd(queue_cmd),
        .cmd_take(queue_take),
        .empty(empty),
        .pop(pop),
        .motor_front_right(motor_front_right),
        .motor_back_left(motor_back_left),
        .motor_front_left(motor_front_left),
        .motor_back_right(motor_back_right),
        .motors_on(motors_on),
        .armed(armed),
        .emergency(emergency),
        .hold_integral(hold_integral)
    );

endmodule

>>> hw/rtl/fss_front.sv
module fss_front (
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  logic [fss_pkg::THROTTLE_W-1:0] throttle,
    input  logic signed [fss_pkg::YAW_W-1:0] yaw_stick,
    input  logic signed [fss_pkg::SAMPLE_W-1:0] gyro_roll_rate,
    input  logic signed [fss_pkg::SAMPLE_W-1:0] roll_angle,
    input  logic signed [fss_pkg::SAMPLE_W-1:0] pitch_angle,
    input  logic signed [fss_pkg::SAMPLE_W-1:0] ctrl_roll,
    input  logic signed [fss_pkg::SAMPLE_W-1:0] ctrl_pitch,
    input  logic signed [fss_pkg::SAMPLE_W-1:0] ctrl_yaw,
    input  logic cfg_write,
    input  logic [fss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fss_pkg::CFG_DATA_W-1:0] cfg_data,
    output fss_pkg::fss_cmd_t cmd
);
    import fss_pkg::*;

    logic [LEVEL_W-1:0] yaw_arm_level_reg;
    logic [ANGLE_LIMIT_W-1:0] safe_angle_reg;
    logic [THROTTLE_W-1:0] throttle_minimum_reg;
    logic [FREEZE_W-1:0] freeze_limit_reg;
    logic angle_stop_enable_reg;

    logic armed_reg, armed_next;
    fss_emerg_t emergency_reg, emergency_next;
    logic [FREEZE_W-1:0] freeze_count_reg, freeze_count_next;
    logic [SAMPLE_W-1:0] last_gyro_reg, last_gyro_next;
    logic grounded_reg, grounded_next;

    logic signed [YAW_W:0] yaw_ext;
    logic signed [YAW_W:0] level_ext;
    logic signed [SAMPLE_W:0] limit_ext;
    logic signed [SAMPLE_W:0] roll_ext;
    logic signed [SAMPLE_W:0] pitch_ext;
    logic [FREEZE_W-1:0] count_inc;
    logic gyro_same;
    logic angle_bad;
    logic run_on;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_arm_level_reg <= YAW_ARM_LEVEL_RESET;
            safe_angle_reg <= SAFE_ANGLE_RESET;
            throttle_minimum_reg <= THROTTLE_MINIMUM_RESET;
            freeze_limit_reg <= FREEZE_LIMIT_RESET;
            angle_stop_enable_reg <= ANGLE_STOP_ENABLE_RESET;
        end
        else if (cfg_write)
        begin
            case (fss_cfg_idx_t'(cfg_index))
                CFG_YAW_ARM_LEVEL: yaw_arm_level_reg <= cfg_data[LEVEL_W-1:0];
                CFG_SAFE_ANGLE: safe_angle_reg <= cfg_data[ANGLE_LIMIT_W-1:0];
                CFG_THROTTLE_MINIMUM: throttle_minimum_reg <= cfg_data[THROTTLE_W-1:0];
                CFG_FREEZE_LIMIT: freeze_limit_reg <= cfg_data[FREEZE_W-1:0];
                CFG_ANGLE_STOP_ENABLE: angle_stop_enable_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign yaw_ext = {yaw_stick[YAW_W-1], yaw_stick};
    assign level_ext = $signed({2'b00, yaw_arm_level_reg});
    assign limit_ext = $signed({2'b00, safe_angle_reg});
    assign roll_ext = {roll_angle[SAMPLE_W-1], roll_angle};
    assign pitch_ext = {pitch_angle[SAMPLE_W-1], pitch_angle};
    assign count_inc = freeze_count_reg + 1'b1;
    assign gyro_same = (gyro_roll_rate == last_gyro_reg);
    assign angle_bad = (roll_ext > limit_ext) || (roll_ext < -limit_ext)
        || (pitch_ext > limit_ext) || (pitch_ext < -limit_ext);

    always_comb
    begin
        armed_next = armed_reg;
        emergency_next = emergency_reg;
        freeze_count_next = freeze_count_reg;
        last_gyro_next = last_gyro_reg;
        grounded_next = grounded_reg;
        run_on = 1'b0;

        cmd.throttle = throttle;
        cmd.ctrl_roll = ctrl_roll;
        cmd.ctrl_pitch = ctrl_pitch;
        cmd.ctrl_yaw = ctrl_yaw;
        cmd.motors_on = 1'b0;
        cmd.armed = armed_reg;
        cmd.emergency = emergency_reg;
        cmd.hold_integral = 1'b1;

        if (emergency_reg == EMERG_NONE)
        begin
            if (throttle == '0 && yaw_ext < -level_ext)
            begin
                armed_next = 1'b0;
            end
            if (throttle == '0 && yaw_ext > level_ext)
            begin
                armed_next = 1'b1;
            end

            if (gyro_same)
            begin
                freeze_count_next = count_inc;
            end
            else
            begin
                freeze_count_next = '0;
                last_gyro_next = gyro_roll_rate;
            end

            if (gyro_same && count_inc == freeze_limit_reg)
            begin
                emergency_next = EMERG_GYRO_FROZEN;
            end
            else if (angle_stop_enable_reg && angle_bad)
            begin
                emergency_next = EMERG_ANGLE;
            end

            cmd.armed = armed_next;
            cmd.emergency = emergency_next;

            if (emergency_next == EMERG_NONE)
            begin
                run_on = armed_next && (throttle >= throttle_minimum_reg);
                grounded_next = !run_on;
                cmd.motors_on = run_on;
                cmd.hold_integral = grounded_reg;
            end
            else
            begin
                grounded_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            emergency_reg <= EMERG_NONE;
            freeze_count_reg <= '0;
            last_gyro_reg <= '0;
            grounded_reg <= 1'b1;
        end
        else if (accept)
        begin
            armed_reg <= armed_next;
            emergency_reg <= emergency_next;
            freeze_count_reg <= freeze_count_next;
            last_gyro_reg <= last_gyro_next;
            grounded_reg <= grounded_next;
        end
    end

endmodule

>>> hw/rtl/fss_queue.sv
module fss_queue #(
    parameter int unsigned DEPTH = fss_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  fss_pkg::fss_cmd_t wr_cmd,
    output logic full,
    input  logic rd_en,
    output logic empty,
    output fss_pkg::fss_cmd_t rd_cmd
);
    import fss_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    fss_cmd_t store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full = (count_reg == FULL_COUNT);
    assign empty = (count_reg == '0);
    assign rd_cmd = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> hw/rtl/fss_back.sv
module fss_back (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  fss_pkg::fss_cmd_t cmd,
    output logic cmd_take,
    output logic empty,
    input  logic pop,
    output logic signed [fss_pkg::MOTOR_W-1:0] motor_front_right,
    output logic signed [fss_pkg::MOTOR_W-1:0] motor_back_left,
    output logic signed [fss_pkg::MOTOR_W-1:0] motor_front_left,
    output logic signed [fss_pkg::MOTOR_W-1:0] motor_back_right,
    output logic motors_on,
    output logic armed,
    output logic [1:0] emergency,
    output logic hold_integral
);
    import fss_pkg::*;

    localparam int unsigned MIX_W = 20;

    function automatic logic signed [MOTOR_W-1:0] round_sat(
        input logic signed [MIX_W-1:0] q4
    );
        logic signed [MIX_W-1:0] biased;
        logic [MIX_W-1:0] mag;
        logic [MIX_W-1:0] whole;
        logic signed [MIX_W-1:0] q;
        logic signed [MOTOR_W-1:0] res;
        biased = q4 + MIX_W'(8);
        mag = biased[MIX_W-1] ? MIX_W'(-biased) : MIX_W'(biased);
        whole = mag >> 4;
        q = biased[MIX_W-1] ? -$signed(whole) : $signed(whole);
        if (q > $signed(MIX_W'(32767)))
        begin
            res = 16'sh7fff;
        end
        else if (q < -$signed(MIX_W'(32768)))
        begin
            res = 16'sh8000;
        end
        else
        begin
            res = q[MOTOR_W-1:0];
        end
        return res;
    endfunction

    logic signed [MIX_W-1:0] t16;
    logic signed [MIX_W-1:0] cr;
    logic signed [MIX_W-1:0] cp;
    logic signed [MIX_W-1:0] cy;
    logic signed [MOTOR_W-1:0] fr_next, bl_next, fl_next, br_next;

    logic out_valid_reg;
    logic signed [MOTOR_W-1:0] fr_reg, bl_reg, fl_reg, br_reg;
    logic motors_on_reg, armed_reg, hold_reg;
    fss_emerg_t emergency_reg;

    assign t16 = $signed({5'b0, cmd.throttle, 4'b0});
    assign cr = MIX_W'(cmd.ctrl_roll);
    assign cp = MIX_W'(cmd.ctrl_pitch);
    assign cy = MIX_W'(cmd.ctrl_yaw);

    always_comb
    begin
        fr_next = '0;
        bl_next = '0;
        fl_next = '0;
        br_next = '0;
        if (cmd.motors_on)
        begin
            fr_next = round_sat(t16 - cr - cp - cy);
            bl_next = round_sat(t16 + cr + cp - cy);
            fl_next = round_sat(t16 + cr - cp + cy);
            br_next = round_sat(t16 - cr + cp + cy);
        end
    end

    assign cmd_take = cmd_valid && (!out_valid_reg || pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            fr_reg <= fr_next;
            bl_reg <= bl_next;
            fl_reg <= fl_next;
            br_reg <= br_next;
            motors_on_reg <= cmd.motors_on;
            armed_reg <= cmd.armed;
            emergency_reg <= cmd.emergency;
            hold_reg <= cmd.hold_integral;
        end
    end

    assign empty = !out_valid_reg;
    assign motor_front_right = fr_reg;
    assign motor_back_left = bl_reg;
    assign motor_front_left = fl_reg;
    assign motor_back_right = br_reg;
    assign motors_on = motors_on_reg;
    assign armed = armed_reg;
    assign emergency = emergency_reg;
    assign hold_integral = hold_reg;

endmodule
